FILE: hw/rtl/key_dbn_pkg.sv
`timescale 1ns / 1ps
package key_dbn_pkg;

   localparam int KEY_COUNT_DEF = 4;
   localparam int PIN_W         = 4;
   localparam int KEY_IDX_W     = 2;
   localparam int DEB_W         = 8;
   localparam int HOLD_W        = 16;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 8;

   localparam logic [DEB_W-1:0]  DEB_RST  = DEB_W'(2);
   localparam logic [HOLD_W-1:0] LONG_RST = HOLD_W'(100);

   localparam logic [CSR_ADDR_W-1:0] CSR_DEBOUNCE = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LONG     = 1'b1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_POLL = 1'b1;

   localparam logic [1:0] MODE_RELEASED = 2'd0;
   localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
   localparam logic [1:0] MODE_PRESSED  = 2'd2;
   localparam logic [1:0] MODE_LONG     = 2'd3;

   typedef struct packed {
      logic tick;
      logic down;
      logic clr_short;
      logic clr_long;
   } lane_ctl_type;

   typedef struct packed {
      logic short_pend;
      logic long_pend;
   } lane_sts_type;

   typedef struct packed {
      logic                 long_press;
      logic [KEY_IDX_W-1:0] key_index;
      logic                 has_event;
   } rsp_item_type;

endpackage

FILE: hw/rtl/key_dbn_lane.sv
`timescale 1ns / 1ps
module key_dbn_lane
   import key_dbn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [DEB_W-1:0]  debounce_ticks,
   input  logic [HOLD_W-1:0] long_press_ticks,
   input  lane_ctl_type      ctl,
   output lane_sts_type      sts
);

   logic [1:0]        mode_ff, mode_in;
   logic [HOLD_W-1:0] count_ff, count_in;
   logic              short_ff, short_in;
   logic              long_ff, long_in;
   logic [HOLD_W-1:0] bumped;

   assign bumped = (count_ff == {HOLD_W{1'b1}}) ? count_ff : count_ff + HOLD_W'(1);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      short_in = short_ff & ~ctl.clr_short;
      long_in  = long_ff & ~ctl.clr_long;
      if (ctl.tick) begin
         case (mode_ff)
            MODE_RELEASED: begin
               if (ctl.down) begin
                  mode_in  = MODE_DEBOUNCE;
                  count_in = '0;
               end
            end
            MODE_DEBOUNCE: begin
               if (ctl.down) begin
                  count_in = bumped;
                  if (bumped >= {{(HOLD_W-DEB_W){1'b0}}, debounce_ticks}) begin
                     mode_in  = MODE_PRESSED;
                     count_in = '0;
                  end
               end else begin
                  mode_in = MODE_RELEASED;
               end
            end
            MODE_PRESSED: begin
               if (!ctl.down) begin
                  short_in = 1'b1;
                  mode_in  = MODE_RELEASED;
               end else begin
                  count_in = bumped;
                  if (bumped >= long_press_ticks) begin
                     mode_in = MODE_LONG;
                  end
               end
            end
            default: begin
               if (!ctl.down) begin
                  long_in = 1'b1;
                  mode_in = MODE_RELEASED;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RELEASED;
         count_ff <= '0;
         short_ff <= 1'b0;
         long_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

   assign sts.short_pend = short_ff;
   assign sts.long_pend  = long_ff;

endmodule

FILE: hw/rtl/key_dbn_pick.sv
`timescale 1ns / 1ps
module key_dbn_pick
   import key_dbn_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEF
) (
   input  logic                 poll,
   input  lane_sts_type         sts [KEY_COUNT],
   output rsp_item_type         item,
   output logic [KEY_COUNT-1:0] clr_short,
   output logic [KEY_COUNT-1:0] clr_long
);

   logic                 found_long;
   logic                 found_short;
   logic [KEY_IDX_W-1:0] idx_long;
   logic [KEY_IDX_W-1:0] idx_short;
   logic [KEY_COUNT-1:0] hot_long;
   logic [KEY_COUNT-1:0] hot_short;

   // lowest index wins: scan downward, last hit stays
   always_comb begin
      found_long  = 1'b0;
      found_short = 1'b0;
      idx_long    = '0;
      idx_short   = '0;
      hot_long    = '0;
      hot_short   = '0;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (sts[k].long_pend) begin
            found_long  = 1'b1;
            idx_long    = KEY_IDX_W'(k);
            hot_long    = '0;
            hot_long[k] = 1'b1;
         end
         if (sts[k].short_pend) begin
            found_short  = 1'b1;
            idx_short    = KEY_IDX_W'(k);
            hot_short    = '0;
            hot_short[k] = 1'b1;
         end
      end
   end

   always_comb begin
      item      = '0;
      clr_long  = '0;
      clr_short = '0;
      if (found_long) begin
         item.has_event  = 1'b1;
         item.key_index  = idx_long;
         item.long_press = 1'b1;
         clr_long        = poll ? hot_long : '0;
      end else if (found_short) begin
         item.has_event  = 1'b1;
         item.key_index  = idx_short;
         clr_short       = poll ? hot_short : '0;
      end
   end

endmodule

FILE: hw/rtl/key_debounce_short_long_press_core.sv
`timescale 1ns / 1ps
// Debouncer for KEY_COUNT active-low keys with short and long press detection. Each request
// transaction is either a tick (tuser = 0) that samples the pin levels in tdata[3:0], or a poll
// (tuser = 1) that returns one response with the highest-priority stored event and clears it:
// long presses before short ones, lowest key first. Ticks give no response. One request is
// taken every cycle while req_tready is high; a poll's response is valid the cycle after
// acceptance unless an earlier response still waits. Responses pass through an output register
// and one skid entry, so req_tready drops only while both hold undelivered responses. Write
// debounce_ticks (index 0) and long_press_ticks (index 1) only while the block is idle.
module key_debounce_short_long_press_core
   import key_dbn_pkg::*;
#(
   parameter int KEY_COUNT = KEY_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [3:0] pin_levels, [7:4] zero
   input  logic                  req_tuser,  // [0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [0] has_event, [2:1] key_index, [3] long_press
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [DEB_W-1:0]  deb_ff;
   logic [HOLD_W-1:0] long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deb_ff  <= DEB_RST;
         long_ff <= LONG_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE: deb_ff  <= csr_wdata[DEB_W-1:0];
            CSR_LONG:     long_ff <= csr_wdata[HOLD_W-1:0];
            default:      ;
         endcase
      end
   end

   logic accept, tick, poll, pop;
   assign accept = req_tvalid & req_tready;
   assign tick   = accept & (req_tuser == OP_TICK);
   assign poll   = accept & (req_tuser == OP_POLL);

   lane_ctl_type         ctl [KEY_COUNT];
   lane_sts_type         sts [KEY_COUNT];
   logic [KEY_COUNT-1:0] clr_short, clr_long;
   rsp_item_type         pick_item;

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
      logic down;
      if (k < PIN_W) begin : g_pin
         assign down = ~req_tdata[k];
      end else begin : g_nopin
         assign down = 1'b1;
      end

      assign ctl[k].tick      = tick;
      assign ctl[k].down      = down;
      assign ctl[k].clr_short = clr_short[k];
      assign ctl[k].clr_long  = clr_long[k];

      key_dbn_lane u_lane (
         .clock            (clock),
         .reset            (reset),
         .debounce_ticks   (deb_ff),
         .long_press_ticks (long_ff),
         .ctl              (ctl[k]),
         .sts              (sts[k])
      );
   end

   key_dbn_pick #(
      .KEY_COUNT (KEY_COUNT)
   ) u_pick (
      .poll      (poll),
      .sts       (sts),
      .item      (pick_item),
      .clr_short (clr_short),
      .clr_long  (clr_long)
   );

   logic         out_vld_ff, out_vld_in;
   logic         skid_vld_ff, skid_vld_in;
   rsp_item_type out_ff, out_in;
   rsp_item_type skid_ff, skid_in;

   assign pop        = out_vld_ff & rsp_tready;
   assign req_tready = ~skid_vld_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (!out_vld_ff || pop) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_in     = pick_item;
            skid_vld_in = poll;
         end else begin
            out_in     = pick_item;
            out_vld_in = poll;
         end
      end else if (poll) begin
         skid_in     = pick_item;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - KEY_IDX_W - 2){1'b0}},
                        out_ff.long_press, out_ff.key_index, out_ff.has_event};

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a response while output register is empty");

   a_tick_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (tick && !out_vld_ff && !skid_vld_ff) |=> !out_vld_ff)
      else $error("tick produced a response");

   a_poll_rsp: assert property (@(posedge clock) disable iff (reset)
      (poll && !out_vld_ff) |=> out_vld_ff)
      else $error("poll lost its response");

   a_one_clear: assert property (@(posedge clock) disable iff (reset)
      $countones({clr_short, clr_long}) <= 1)
      else $error("poll cleared more than one pending flag");

   a_clear_only_on_poll: assert property (@(posedge clock) disable iff (reset)
      ((|clr_short) || (|clr_long)) |-> (poll && pick_item.has_event))
      else $error("pending flag cleared outside a reporting poll");

endmodule
